// ===== sv/one_wire_bus_master_macros.svh =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_macros: assertion helpers
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OWBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants
// command classes, queue entry, result item, register map and status codes
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int TIMEOUT_BITS_DEF = 20;

  // opcodes on the tick channel
  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WAIT  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_PRESENCE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT     = 2'd2;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRES_WAIT   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRES_TAIL   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_SLOT   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_SLOT  = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_WAIT = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_TAIL   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 4'd7;

  // register reset values
  localparam logic [9:0]  RST_RESET_LOW   = 10'd500;
  localparam logic [7:0]  RST_PRES_WAIT   = 8'd80;
  localparam logic [9:0]  RST_PRES_TAIL   = 10'd250;
  localparam logic [7:0]  RST_LONG_SLOT   = 8'd60;
  localparam logic [5:0]  RST_SHORT_SLOT  = 6'd2;
  localparam logic [5:0]  RST_SAMPLE_WAIT = 6'd10;
  localparam logic [7:0]  RST_READ_TAIL   = 8'd50;
  localparam logic [19:0] RST_TIMEOUT     = 20'd1000000;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command class worked out by the front
  typedef enum logic [4:0] {
    CL_NONE  = 5'b00001,
    CL_RESET = 5'b00010,
    CL_WRITE = 5'b00100,
    CL_READ  = 5'b01000,
    CL_WAIT  = 5'b10000
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] tx_byte;
    logic       line_in;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } res_t;

endpackage

// ===== sv/owbm_if.sv =====
// ----------------------------------------------------------------------------
// owbm_if: channel interfaces
// tick input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface owbm_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] opcode;
  logic [7:0] tx_byte;
  logic       line_in;

  modport source (output valid, cmd_valid, opcode, tx_byte, line_in, input ready);
  modport sink   (input valid, cmd_valid, opcode, tx_byte, line_in, output ready);
endinterface

interface owbm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic [1:0] status;

  modport source (output valid, drive_low, busy_res, done_res, rx_byte, status,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, rx_byte, status,
                  output ready);
endinterface

interface owbm_cfg_if import owbm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/owbm_front.sv =====
// ----------------------------------------------------------------------------
// owbm_front: tick intake
// registers each tick and classifies its command for the back end
// ----------------------------------------------------------------------------
module owbm_front import owbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd_valid,
  input  logic [1:0] opcode,
  input  logic [7:0] tx_byte,
  input  logic       line_in,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  logic  hold_valid;
  item_t hold_item;
  item_t dec_item;

  always_comb begin
    dec_item.tx_byte = tx_byte;
    dec_item.line_in = line_in;
    dec_item.cls     = CL_NONE;
    if (cmd_valid) begin
      unique case (opcode)
        OP_RESET: dec_item.cls = CL_RESET;
        OP_WRITE: dec_item.cls = CL_WRITE;
        OP_READ:  dec_item.cls = CL_READ;
        OP_WAIT:  dec_item.cls = CL_WAIT;
        default:  dec_item.cls = CL_NONE;
      endcase
    end
  end

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= dec_item;
    end
  end

endmodule

// ===== sv/owbm_queue.sv =====
// ----------------------------------------------------------------------------
// owbm_queue: short queue between front and back
// two entries, head read straight from the entry registers
// ----------------------------------------------------------------------------
module owbm_queue import owbm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = push_valid && push_ready;
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/owbm_back.sv =====
// ----------------------------------------------------------------------------
// owbm_back: bus sequencer
// runs the slot timing one tick per queue entry, holds the timing registers
// and the result register
// ----------------------------------------------------------------------------
`include "one_wire_bus_master_macros.svh"

module owbm_back import owbm_pkg::*; #(
  parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  item_t                  q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output res_t                   out_res,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_RST_LOW  = 13'b0000000000010,
    PH_RST_WAIT = 13'b0000000000100,
    PH_RST_TAIL = 13'b0000000001000,
    PH_WR_LOW   = 13'b0000000010000,
    PH_WR_REL   = 13'b0000000100000,
    PH_RD_LOW   = 13'b0000001000000,
    PH_RD_WAIT  = 13'b0000010000000,
    PH_RD_TAIL  = 13'b0000100000000,
    PH_WT_LOW   = 13'b0001000000000,
    PH_WT_WAIT  = 13'b0010000000000,
    PH_WT_TAIL  = 13'b0100000000000,
    PH_WT_GAP   = 13'b1000000000000
  } phase_t;

  // timing registers
  logic [9:0]  reset_low_time;
  logic [7:0]  presence_wait;
  logic [9:0]  presence_tail;
  logic [7:0]  long_slot;
  logic [5:0]  short_slot;
  logic [5:0]  read_sample_wait;
  logic [7:0]  read_tail;
  logic [19:0] ready_timeout;

  // sequencer state
  phase_t                  phase, phase_next;
  logic [9:0]              slot_timer, slot_timer_next;
  logic [TIMEOUT_BITS-1:0] poll_count, poll_count_next;
  logic [2:0]              bit_index, bit_index_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [1:0]              last_status, last_status_next;
  logic                    sample_bit, sample_bit_next;
  logic [7:0]              rx_reg, rx_reg_next;

  logic                    step;
  logic [TIMEOUT_BITS-1:0] poll_load;
  logic [9:0]              timer_inc;
  logic [9:0]              len_raw;
  logic [9:0]              len;
  logic                    cur_bit;
  res_t                    res_next;

  assign step      = q_valid && (!out_valid || out_ready);
  assign q_pop     = step;
  assign poll_load = TIMEOUT_BITS'(ready_timeout);

  always_comb begin
    phase_next       = phase;
    slot_timer_next  = slot_timer;
    poll_count_next  = poll_count;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    last_status_next = last_status;
    sample_bit_next  = sample_bit;
    rx_reg_next      = rx_reg;
    res_next         = '0;
    timer_inc        = '0;
    len_raw          = '0;
    len              = '0;
    cur_bit          = 1'b0;

    // command start, the start tick is already the first phase tick
    if (phase == PH_IDLE) begin
      unique case (q_item.cls)
        CL_RESET: begin
          phase_next      = PH_RST_LOW;
          slot_timer_next = '0;
          bit_index_next  = '0;
          sample_bit_next = 1'b0;
        end
        CL_WRITE: begin
          phase_next      = PH_WR_LOW;
          slot_timer_next = '0;
          bit_index_next  = '0;
          sample_bit_next = 1'b0;
          shift_byte_next = q_item.tx_byte;
        end
        CL_READ: begin
          phase_next      = PH_RD_LOW;
          slot_timer_next = '0;
          bit_index_next  = '0;
          sample_bit_next = 1'b0;
          shift_byte_next = '0;
        end
        CL_WAIT: begin
          slot_timer_next = '0;
          bit_index_next  = '0;
          sample_bit_next = 1'b0;
          poll_count_next = poll_load;
          if (poll_load == '0) begin
            last_status_next  = ST_TIMEOUT;
            res_next.busy_res = 1'b1;
            res_next.done_res = 1'b1;
          end else begin
            phase_next = PH_WT_LOW;
          end
        end
        CL_NONE: ;
        default: ;
      endcase
    end

    if (phase_next != PH_IDLE) begin
      res_next.busy_res  = 1'b1;
      res_next.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                           (phase_next == PH_RD_LOW)  || (phase_next == PH_WT_LOW);
      cur_bit   = shift_byte_next[bit_index_next];
      timer_inc = slot_timer_next + 10'd1;

      unique case (phase_next)
        PH_RST_LOW:  len_raw = reset_low_time;
        PH_RST_WAIT: len_raw = 10'(presence_wait);
        PH_RST_TAIL: len_raw = presence_tail;
        PH_WR_LOW:   len_raw = cur_bit ? 10'(short_slot) : 10'(long_slot);
        PH_WR_REL:   len_raw = cur_bit ? 10'(long_slot) : 10'(short_slot);
        PH_RD_LOW, PH_WT_LOW:   len_raw = 10'(short_slot);
        PH_RD_WAIT, PH_WT_WAIT: len_raw = 10'(read_sample_wait);
        PH_RD_TAIL, PH_WT_TAIL: len_raw = 10'(read_tail);
        default:     len_raw = 10'd1;
      endcase
      len = (len_raw == '0) ? 10'd1 : len_raw;

      slot_timer_next = timer_inc;
      if (timer_inc >= len || timer_inc == '0) begin
        slot_timer_next = '0;
        unique case (phase_next)
          PH_RST_LOW:  phase_next = PH_RST_WAIT;
          PH_RST_WAIT: begin
            sample_bit_next = q_item.line_in;
            phase_next      = PH_RST_TAIL;
          end
          PH_RST_TAIL: begin
            last_status_next  = sample_bit_next ? ST_NO_PRESENCE : ST_OK;
            phase_next        = PH_IDLE;
            res_next.done_res = 1'b1;
          end
          PH_WR_LOW:   phase_next = PH_WR_REL;
          PH_WR_REL: begin
            bit_index_next = bit_index_next + 3'd1;
            if (bit_index_next != '0) begin
              phase_next = PH_WR_LOW;
            end else begin
              last_status_next  = ST_OK;
              phase_next        = PH_IDLE;
              res_next.done_res = 1'b1;
            end
          end
          PH_RD_LOW:   phase_next = PH_RD_WAIT;
          PH_RD_WAIT: begin
            if (q_item.line_in) begin
              shift_byte_next[bit_index_next] = 1'b1;
            end
            phase_next = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            bit_index_next = bit_index_next + 3'd1;
            if (bit_index_next != '0) begin
              phase_next = PH_RD_LOW;
            end else begin
              rx_reg_next       = shift_byte_next;
              last_status_next  = ST_OK;
              phase_next        = PH_IDLE;
              res_next.done_res = 1'b1;
            end
          end
          PH_WT_LOW:   phase_next = PH_WT_WAIT;
          PH_WT_WAIT: begin
            sample_bit_next = q_item.line_in;
            phase_next      = PH_WT_TAIL;
          end
          PH_WT_TAIL: begin
            if (sample_bit_next) begin
              last_status_next  = ST_OK;
              phase_next        = PH_IDLE;
              res_next.done_res = 1'b1;
            end else begin
              phase_next = PH_WT_GAP;
            end
          end
          PH_WT_GAP: begin
            poll_count_next = poll_count_next - 1'b1;
            if (poll_count_next != '0) begin
              phase_next = PH_WT_LOW;
            end else begin
              last_status_next  = ST_TIMEOUT;
              phase_next        = PH_IDLE;
              res_next.done_res = 1'b1;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    res_next.rx_byte = rx_reg_next;
    res_next.status  = last_status_next;
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      slot_timer  <= '0;
      poll_count  <= '0;
      bit_index   <= '0;
      shift_byte  <= '0;
      last_status <= ST_OK;
      sample_bit  <= 1'b0;
      rx_reg      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        phase       <= phase_next;
        slot_timer  <= slot_timer_next;
        poll_count  <= poll_count_next;
        bit_index   <= bit_index_next;
        shift_byte  <= shift_byte_next;
        last_status <= last_status_next;
        sample_bit  <= sample_bit_next;
        rx_reg      <= rx_reg_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res_next;
    end
  end

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time   <= RST_RESET_LOW;
      presence_wait    <= RST_PRES_WAIT;
      presence_tail    <= RST_PRES_TAIL;
      long_slot        <= RST_LONG_SLOT;
      short_slot       <= RST_SHORT_SLOT;
      read_sample_wait <= RST_SAMPLE_WAIT;
      read_tail        <= RST_READ_TAIL;
      ready_timeout    <= RST_TIMEOUT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESET_LOW:   reset_low_time   <= cfg_data[9:0];
        REG_PRES_WAIT:   presence_wait    <= cfg_data[7:0];
        REG_PRES_TAIL:   presence_tail    <= cfg_data[9:0];
        REG_LONG_SLOT:   long_slot        <= cfg_data[7:0];
        REG_SHORT_SLOT:  short_slot       <= cfg_data[5:0];
        REG_SAMPLE_WAIT: read_sample_wait <= cfg_data[5:0];
        REG_READ_TAIL:   read_tail        <= cfg_data[7:0];
        REG_TIMEOUT:     ready_timeout    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // a held result freezes the sequencer
  `OWBM_ASSERT_NEXT(a_stall_holds_state, out_valid && !out_ready,
    $stable(phase) && $stable(slot_timer) && $stable(bit_index), "state moved under stall")
  // every command ends with the bit counter wrapped back
  `OWBM_ASSERT_IMP(a_idle_bit_zero, phase == PH_IDLE, bit_index == '0,
    "bit index not zero when idle")
  // a finishing tick is always a busy tick
  `OWBM_ASSERT_IMP(a_done_busy, out_valid && out_res.done_res, out_res.busy_res,
    "done without busy")

endmodule

// ===== sv/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-wire bus master timed in microsecond ticks
// every tick transfer carries an optional command and the sampled line level;
// every tick gives one result transfer with drive, busy, done, byte and status
// ----------------------------------------------------------------------------
// channels: tick (in), res (out), cfg (register writes, always ready)
// one tick transfer in gives exactly one res transfer out, in order
// commands: reset with presence detect, write byte, read byte, wait ready;
// a command offered while another runs is dropped, bytes go lsb first
// path: each tick goes through the intake register, a queue entry and the
// result register before its result is offered on res
// throughput: one tick per clock cycle unless res stalls; the sequencer does
// one tick of bus time per cycle in one step, so nothing iterates inside a tick
// stall: while res is held the sequencer freezes; the queue and the intake
// register still take up to three further ticks before tick.ready drops
// reset: synchronous rst empties the queue and result register, returns the
// sequencer to idle with byte and status zero, and loads the timing
// registers with their default values
// cfg writes are meant for idle periods; an index past the register list is
// dropped
// ----------------------------------------------------------------------------
module one_wire_bus_master import owbm_pkg::*; #(
  parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  owbm_tick_if.sink  tick,
  owbm_res_if.source res,
  owbm_cfg_if.sink   cfg
);

  // front to queue
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // queue to back
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // result register
  logic  out_valid;
  res_t  out_res;

  // register writes are taken on any cycle
  assign cfg.ready = 1'b1;

  // intake and command classification
  owbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (tick.valid),
    .in_ready   (tick.ready),
    .cmd_valid  (tick.cmd_valid),
    .opcode     (tick.opcode),
    .tx_byte    (tick.tx_byte),
    .line_in    (tick.line_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples intake from the sequencer
  owbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // slot sequencer, timing registers and result register
  owbm_back #(
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (res.ready),
    .out_res   (out_res),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
  );

  // result transfer
  assign res.valid     = out_valid;
  assign res.drive_low = out_res.drive_low;
  assign res.busy_res  = out_res.busy_res;
  assign res.done_res  = out_res.done_res;
  assign res.rx_byte   = out_res.rx_byte;
  assign res.status    = out_res.status;

endmodule
